### hdl/erf_pkg.sv
package erf_pkg;

  localparam logic [7:0] FLAG_BYTE    = 8'h7E;
  localparam logic [7:0] ESC_BYTE     = 8'h7D;
  localparam logic [7:0] ESC_FLAG     = 8'h5E;
  localparam logic [7:0] ESC_ESC      = 8'h5D;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam int unsigned MIN_FRAME_BYTES = 4;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_FLAG  = 3'd1,
    ST_CRC_ERR   = 3'd2,
    ST_TOO_SHORT = 3'd3,
    ST_TOO_LONG  = 3'd4
  } frame_status_t;

  // One decoded event: a decoded data byte, or the end of a buffer.
  typedef struct packed {
    logic       is_end;
    logic       bad_flag;
    logic [7:0] data;
  } event_t;

  typedef struct packed {
    logic          is_status;
    logic [7:0]    payload_byte;
    frame_status_t frame_status;
    logic          last_item;
  } result_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### hdl/erf_front.sv
module erf_front
  import erf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       buffer_end,
  output logic       ev_valid,
  input  logic       ev_ready,
  output event_t     ev
);

  logic       expect_opening;
  logic       bad_opening;
  logic       escape_pending;
  event_t     ev0;
  event_t     ev1;
  logic [1:0] pcnt;

  logic       expect_opening_next;
  logic       bad_opening_next;
  logic       escape_pending_next;
  event_t     new_a;
  event_t     new_b;
  logic [1:0] new_n;
  logic       accept;
  logic       take;

  assign ev_valid = (pcnt != 2'd0);
  assign ev       = ev0;
  assign take     = ev_valid && ev_ready;
  assign in_ready = (pcnt == 2'd0) || ((pcnt == 2'd1) && ev_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    expect_opening_next = expect_opening;
    bad_opening_next    = bad_opening;
    escape_pending_next = escape_pending;
    new_a = '0;
    new_b = '0;
    new_n = 2'd0;
    if (expect_opening) begin
      expect_opening_next = 1'b0;
      bad_opening_next    = (rx_byte != FLAG_BYTE);
      if (buffer_end) begin
        new_a = '{is_end: 1'b1, bad_flag: (rx_byte != FLAG_BYTE), data: 8'h00};
        new_n = 2'd1;
        expect_opening_next = 1'b1;
        bad_opening_next    = 1'b0;
        escape_pending_next = 1'b0;
      end
    end else if (!buffer_end) begin
      if (escape_pending) begin
        escape_pending_next = 1'b0;
        if (rx_byte == ESC_FLAG) begin
          new_a = '{is_end: 1'b0, bad_flag: 1'b0, data: FLAG_BYTE};
          new_n = 2'd1;
        end else if (rx_byte == ESC_ESC) begin
          new_a = '{is_end: 1'b0, bad_flag: 1'b0, data: ESC_BYTE};
          new_n = 2'd1;
        end else begin
          new_a = '{is_end: 1'b0, bad_flag: 1'b0, data: ESC_BYTE};
          if (rx_byte == ESC_BYTE) begin
            escape_pending_next = 1'b1;
            new_n = 2'd1;
          end else begin
            new_b = '{is_end: 1'b0, bad_flag: 1'b0, data: rx_byte};
            new_n = 2'd2;
          end
        end
      end else if (rx_byte == ESC_BYTE) begin
        escape_pending_next = 1'b1;
      end else begin
        new_a = '{is_end: 1'b0, bad_flag: 1'b0, data: rx_byte};
        new_n = 2'd1;
      end
    end else begin
      if (escape_pending) begin
        new_a = '{is_end: 1'b0, bad_flag: 1'b0, data: ESC_BYTE};
        new_b = '{is_end: 1'b1, bad_flag: bad_opening || (rx_byte != FLAG_BYTE), data: 8'h00};
        new_n = 2'd2;
      end else begin
        new_a = '{is_end: 1'b1, bad_flag: bad_opening || (rx_byte != FLAG_BYTE), data: 8'h00};
        new_n = 2'd1;
      end
      expect_opening_next = 1'b1;
      bad_opening_next    = 1'b0;
      escape_pending_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_opening <= 1'b1;
      bad_opening    <= 1'b0;
      escape_pending <= 1'b0;
      pcnt           <= 2'd0;
    end else if (accept) begin
      expect_opening <= expect_opening_next;
      bad_opening    <= bad_opening_next;
      escape_pending <= escape_pending_next;
      pcnt           <= new_n;
    end else if (take) begin
      pcnt <= pcnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ev0 <= new_a;
      ev1 <= new_b;
    end else if (take) begin
      ev0 <= ev1;
    end
  end

endmodule

### hdl/erf_queue.sv
module erf_queue
  import erf_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  event_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output event_t out_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  event_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push;
  logic               pop;

  assign in_ready  = (count != CNT_W'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

endmodule

### hdl/erf_back.sv
module erf_back
  import erf_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    ev_valid,
  output logic    ev_ready,
  input  event_t  ev,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_item
);

  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

  logic [7:0]       held0;
  logic [7:0]       held1;
  logic [1:0]       held_count;
  logic [CNT_W-1:0] decoded_count;
  logic [15:0]      running_crc;
  logic             overflow_seen;

  logic [7:0]       held0_next;
  logic [7:0]       held1_next;
  logic [1:0]       held_count_next;
  logic [CNT_W-1:0] decoded_count_next;
  logic [15:0]      running_crc_next;
  logic             overflow_seen_next;
  logic             emit;
  result_t          item_next;
  frame_status_t    status;
  logic             pop;

  assign pop      = ev_valid && (!out_valid || out_ready);
  assign ev_ready = !out_valid || out_ready;

  always_comb begin
    if (ev.bad_flag) begin
      status = ST_BAD_FLAG;
    end else if (overflow_seen) begin
      status = ST_TOO_LONG;
    end else if (decoded_count < CNT_W'(MIN_FRAME_BYTES)) begin
      status = ST_TOO_SHORT;
    end else if ({held0, held1} != running_crc) begin
      status = ST_CRC_ERR;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    held0_next         = held0;
    held1_next         = held1;
    held_count_next    = held_count;
    decoded_count_next = decoded_count;
    running_crc_next   = running_crc;
    overflow_seen_next = overflow_seen;
    emit               = 1'b0;
    item_next          = '{is_status: 1'b0, payload_byte: 8'h00, frame_status: ST_OK,
                           last_item: 1'b0};
    if (ev.is_end) begin
      emit      = 1'b1;
      item_next = '{is_status: 1'b1, payload_byte: 8'h00, frame_status: status,
                    last_item: 1'b1};
      held0_next         = 8'h00;
      held1_next         = 8'h00;
      held_count_next    = 2'd0;
      decoded_count_next = '0;
      running_crc_next   = 16'h0000;
      overflow_seen_next = 1'b0;
    end else begin
      if (held_count[1]) begin
        running_crc_next = crc_feed(running_crc, held0);
        if (decoded_count >= CNT_W'(MIN_FRAME_BYTES)) begin
          emit = 1'b1;
          item_next.payload_byte = held0;
        end
        held0_next = held1;
        held1_next = ev.data;
      end else begin
        if (held_count[0]) begin
          held1_next = ev.data;
        end else begin
          held0_next = ev.data;
        end
        held_count_next = held_count + 2'd1;
      end
      if (decoded_count < CNT_W'(MAX_FRAME_BYTES)) begin
        decoded_count_next = decoded_count + CNT_W'(1);
      end else begin
        overflow_seen_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held0         <= 8'h00;
      held1         <= 8'h00;
      held_count    <= 2'd0;
      decoded_count <= '0;
      running_crc   <= 16'h0000;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else if (pop) begin
      held0         <= held0_next;
      held1         <= held1_next;
      held_count    <= held_count_next;
      decoded_count <= decoded_count_next;
      running_crc   <= running_crc_next;
      overflow_seen <= overflow_seen_next;
      out_valid     <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_item <= item_next;
    end
  end

endmodule

### hdl/escaped_crc_frame_receiver.sv
// Path: a byte's events are registered in the front, stored in the queue and registered
//   again in the back before a result they cause is valid.
// Throughput: one byte per cycle while the queue and output accept; the front hands one
//   event per cycle to the queue, so a byte that yields two events (a lone escape before
//   a byte other than 5E, 5D or 7D, or an escape before the closing flag) holds the next byte.
// Reset: synchronous, active high; clears all frame state and the event
//   queue, and the next byte opens a new buffer.
module escaped_crc_frame_receiver
  import erf_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte
  input  logic        s_tlast,   // buffer_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // payload_byte [7:0], frame_status [10:8], zero [15:11]
  output logic        m_tuser,   // is_status
  output logic        m_tlast    // last_item
);

  logic    fq_valid;
  logic    fq_ready;
  event_t  fq_data;
  logic    qb_valid;
  logic    qb_ready;
  event_t  qb_data;
  result_t item;

  erf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .rx_byte    (s_tdata),
    .buffer_end (s_tlast),
    .ev_valid   (fq_valid),
    .ev_ready   (fq_ready),
    .ev         (fq_data)
  );

  erf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_data),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_data  (qb_data)
  );

  erf_back #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .ev_valid  (qb_valid),
    .ev_ready  (qb_ready),
    .ev        (qb_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (item)
  );

  assign m_tdata = {5'b00000, item.frame_status, item.payload_byte};
  assign m_tuser = item.is_status;
  assign m_tlast = item.last_item;

endmodule
